### rtl/civil_date_to_epoch_seconds_assert.svh
// Assertion macros shared by the civil date to epoch seconds RTL.
`ifndef CIVIL_DATE_TO_EPOCH_SECONDS_ASSERT_SVH
`define CIVIL_DATE_TO_EPOCH_SECONDS_ASSERT_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define CDTE_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cdte assertion failed");

// Check that cons holds in the cycle after ante holds.
`define CDTE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cdte assertion failed");

`endif

### rtl/cdte_pkg.sv
// Shared types, constants and tables for the civil date to epoch seconds block.
package cdte_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NO_CLOCK     = 3'd1,
    ST_IMPLAUSIBLE  = 3'd2,
    ST_BEFORE_EPOCH = 3'd3,
    ST_TOO_LATE     = 3'd4
  } status_t;

  // Calendar and time constants
  localparam int EPOCH_YEAR       = 1970;
  localparam int YEARS_PER_ERA    = 400;
  localparam int DAYS_PER_YEAR    = 365;
  localparam int DAYS_PER_ERA     = 146097;
  localparam int EPOCH_SHIFT_DAYS = 719468;
  localparam int SECS_PER_DAY     = 86400;
  localparam int SECS_PER_HOUR    = 3600;
  localparam int SECS_PER_MIN     = 60;

  // y / 400 as (y * ERA_RECIP) >> ERA_RECIP_SHIFT, exact for y below 4096
  localparam int ERA_RECIP       = 5243;
  localparam int ERA_RECIP_SHIFT = 21;

  // Depth of the queue between classifier and arithmetic pipeline
  localparam int QUEUE_DEPTH = 4;

  // Classified item handed from the front to the back
  typedef struct packed {
    status_t     status;  // ST_OK means: compute the seconds
    logic [11:0] y;       // year, one less for January and February
    logic [3:0]  mp;      // month index counted from March, 0..11
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } job_t;

  // Days from March 1 to the first of month index mp, i.e. (153*mp+2)/5
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] d;
    unique case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

### rtl/cdte_front.sv
// Front end: configuration register, input unpacking and status classification.
module cdte_front import cdte_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic        in_tuser,
  output logic        push_valid,
  input  logic        push_ready,
  output job_t        push_job
);

  logic        clock_present_r;
  logic        clock_present_nxt;
  logic [11:0] year;
  logic [7:0]  month;
  logic [7:0]  day;
  logic [7:0]  hour;
  logic [7:0]  minute;
  logic [7:0]  second;
  logic        early_month;
  logic        implausible;
  logic [7:0]  mp_full;

  // Take a configuration write in any cycle
  assign cfg_ready = 1'b1;

  always_comb begin
    clock_present_nxt = clock_present_r;
    if (cfg_valid) begin
      clock_present_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_present_r <= 1'b0;
    end else begin
      clock_present_r <= clock_present_nxt;
    end
  end

  // Unpack the input item
  assign year   = in_tdata[11:0];
  assign month  = in_tdata[19:12];
  assign day    = in_tdata[27:20];
  assign hour   = in_tdata[35:28];
  assign minute = in_tdata[43:36];
  assign second = in_tdata[51:44];

  assign early_month = (month <= 8'd2);
  assign implausible = (month == 8'd0) || (month > 8'd12) ||
                       (day == 8'd0) || (day > 8'd31) ||
                       (hour > 8'd23) || (minute > 8'd59) || (second > 8'd59);
  assign mp_full = early_month ? (month + 8'd9) : (month - 8'd3);

  // Classify in the order of the status codes, first failure wins
  always_comb begin
    push_job.y      = year - {11'd0, early_month};
    push_job.mp     = mp_full[3:0];
    push_job.day    = day[4:0];
    push_job.hour   = hour[4:0];
    push_job.minute = minute[5:0];
    push_job.second = second[5:0];
    if (!clock_present_r || !in_tuser) begin
      push_job.status = ST_NO_CLOCK;
    end else if (implausible) begin
      push_job.status = ST_IMPLAUSIBLE;
    end else if (year < 12'(EPOCH_YEAR)) begin
      push_job.status = ST_BEFORE_EPOCH;
    end else begin
      push_job.status = ST_OK;
    end
  end

  // Hand the item straight to the queue
  assign push_valid = in_tvalid;
  assign in_tready  = push_ready;

endmodule

### rtl/cdte_fifo.sv
// Short register queue that decouples the classifier from the arithmetic pipeline.
`include "civil_date_to_epoch_seconds_assert.svh"
module cdte_fifo import cdte_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  `CDTE_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH))
  `CDTE_ASSERT_NEXT(a_count_up, push_fire && !pop_fire, count_r == CNT_W'($past(count_r) + 1'b1))
  `CDTE_ASSERT_IMPL(a_empty_ptrs, count_r == '0, rd_ptr_r == wr_ptr_r)

endmodule

### rtl/cdte_back.sv
// Back end: six-stage days-from-civil and seconds pipeline with output register.
`include "civil_date_to_epoch_seconds_assert.svh"
module cdte_back import cdte_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  job_t        pop_job,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic [2:0]  out_tuser
);

  logic        en;
  logic        v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  status_t     st1_r, st2_r, st3_r, st4_r, st5_r, out_status_r;
  logic [31:0] out_epoch_r;

  // Stage 1 terms
  logic [24:0] era_prod;
  logic [11:0] y1_r;
  logic [3:0]  era1_r;
  logic [8:0]  doy1_r;
  logic [16:0] hms1_r;
  logic [8:0]  doy_nxt;
  logic [16:0] hms_nxt;
  // Stage 2 terms
  logic [11:0] era_x400;
  logic [11:0] yoe_full;
  logic [8:0]  yoe2_r;
  logic [3:0]  era2_r;
  logic [8:0]  doy2_r;
  logic [16:0] hms2_r;
  // Stage 3 terms
  logic [1:0]  cent;
  logic [17:0] doe_nxt;
  logic [17:0] doe3_r;
  logic [3:0]  era3_r;
  logic [16:0] hms3_r;
  // Stage 4 terms
  logic [20:0] shifted;
  logic [19:0] days4_r;
  logic [16:0] hms4_r;
  // Stage 5 terms
  logic [36:0] total5_r;

  // Whole pipeline moves when the output register is free or being taken
  assign en        = !out_valid_r || out_tready;
  assign pop_ready = en;

  assign era_prod = 25'(pop_job.y) * 25'(ERA_RECIP);
  assign doy_nxt  = month_start(pop_job.mp) + 9'(pop_job.day) - 9'd1;
  assign hms_nxt  = 17'(pop_job.hour) * 17'(SECS_PER_HOUR) +
                    17'(pop_job.minute) * 17'(SECS_PER_MIN) + 17'(pop_job.second);

  assign era_x400 = 12'(era1_r) * 12'(YEARS_PER_ERA);
  assign yoe_full = y1_r - era_x400;

  assign cent    = 2'(yoe2_r >= 9'd100) + 2'(yoe2_r >= 9'd200) + 2'(yoe2_r >= 9'd300);
  assign doe_nxt = 18'(yoe2_r) * 18'(DAYS_PER_YEAR) + 18'(yoe2_r[8:2]) - 18'(cent) +
                   18'(doy2_r);

  assign shifted = 21'(era3_r) * 21'(DAYS_PER_ERA) + 21'(doe3_r);

  // Hold control in reset, advance valids on enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= pop_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  // Advance payload through the stages
  always_ff @(posedge clk) begin
    if (en) begin
      // era, day of year, time of day
      st1_r  <= pop_job.status;
      y1_r   <= pop_job.y;
      era1_r <= era_prod[24:ERA_RECIP_SHIFT];
      doy1_r <= doy_nxt;
      hms1_r <= hms_nxt;
      // year of era
      st2_r  <= st1_r;
      yoe2_r <= yoe_full[8:0];
      era2_r <= era1_r;
      doy2_r <= doy1_r;
      hms2_r <= hms1_r;
      // day of era
      st3_r  <= st2_r;
      doe3_r <= doe_nxt;
      era3_r <= era2_r;
      hms3_r <= hms2_r;
      // days since 1970
      st4_r   <= st3_r;
      days4_r <= 20'(shifted - 21'(EPOCH_SHIFT_DAYS));
      hms4_r  <= hms3_r;
      // total seconds
      st5_r    <= st4_r;
      total5_r <= 37'(days4_r) * 37'(SECS_PER_DAY) + 37'(hms4_r);
      // range check and result
      if (st5_r != ST_OK) begin
        out_status_r <= st5_r;
        out_epoch_r  <= '0;
      end else if (total5_r[36:32] != '0) begin
        out_status_r <= ST_TOO_LATE;
        out_epoch_r  <= '0;
      end else begin
        out_status_r <= ST_OK;
        out_epoch_r  <= total5_r[31:0];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_epoch_r;
  assign out_tuser  = out_status_r;

  `CDTE_ASSERT_IMPL(a_fail_zero, out_valid_r && out_status_r != ST_OK, out_epoch_r == '0)
  `CDTE_ASSERT_NEXT(a_stall_holds, v5_r && !en, v5_r && out_valid_r)
  `CDTE_ASSERT_NEXT(a_pop_lands, pop_valid && en, v1_r)

endmodule

### rtl/civil_date_to_epoch_seconds.sv
// Civil date-time reading to seconds since 1970-01-01 UTC, top level.
// Converts one clock-chip reading per cycle while out_tready is high to Unix
// seconds with the Gregorian days-from-civil method. An accepted item enters a
// small queue, then a six-stage arithmetic pipeline whose last stage is the output
// register; the whole pipeline stalls while a result waits. One item per cycle is
// taken sustained; the queue (QDEPTH items) absorbs output back-pressure before
// in_tready drops. out_tuser carries the status: 0 ok, 1 no clock or read failed,
// 2 implausible field, 3 before 1970, 4 beyond 32 bits; out_tdata is zero unless
// the status is ok. A day up to 31 is accepted in any month and rolls into the
// next. clock_present is written on the cfg channel, always ready, and resets to 0.
module civil_date_to_epoch_seconds import cdte_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,    // clock_present
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,    // year[11:0], month, day, hour, minute, second, pad
  input  logic        in_tuser,    // read_ok
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // epoch_seconds
  output logic [2:0]  out_tuser    // status
);

  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic pop_valid;
  logic pop_ready;
  job_t pop_job;

  cdte_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  cdte_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  cdte_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### verif/tb_civil_date_to_epoch_seconds.sv
// Self-checking testbench for the civil date to epoch seconds converter.
`timescale 1ns / 1ps

module tb_civil_date_to_epoch_seconds;
  import cdte_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 12;

  // One clock-chip reading as it enters the block
  typedef struct {
    bit        read_ok;
    bit [11:0] year;
    bit [7:0]  month;
    bit [7:0]  day;
    bit [7:0]  hour;
    bit [7:0]  minute;
    bit [7:0]  second;
  } date_reading_t;

  // Converted time as it leaves the block
  typedef struct {
    status_t   status;
    bit [31:0] seconds;
  } epoch_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;

  epoch_result_t pending_epochs[$];
  bit            clock_present_model;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            failures;
  int            readings_sent;
  int            results_checked;
  int            status_seen[5];
  int            cycle_count;

  civil_date_to_epoch_seconds dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_epochs.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compute status and seconds for one reading with days-from-civil
  function automatic epoch_result_t predict_epoch(bit present, date_reading_t r);
    epoch_result_t     res;
    longint unsigned y, era, yoe, mp, doy, doe, days, total;
    res.status = ST_OK;
    res.seconds = '0;
    if (!present || !r.read_ok) begin
      res.status = ST_NO_CLOCK;
    end else if (r.month < 1 || r.month > 12 || r.day < 1 || r.day > 31 ||
                 r.hour > 23 || r.minute > 59 || r.second > 59) begin
      res.status = ST_IMPLAUSIBLE;
    end else if (r.year < EPOCH_YEAR) begin
      res.status = ST_BEFORE_EPOCH;
    end else begin
      // Count the year from March so the leap day falls last
      y = 64'(r.year);
      if (r.month <= 2) y = y - 1;
      era = y / YEARS_PER_ERA;
      yoe = y - era * YEARS_PER_ERA;
      mp = (r.month > 2) ? r.month - 3 : r.month + 9;
      doy = (153 * mp + 2) / 5 + r.day - 1;
      doe = yoe * DAYS_PER_YEAR + yoe / 4 - yoe / 100 + doy;
      days = era * DAYS_PER_ERA + doe - EPOCH_SHIFT_DAYS;
      total = days * SECS_PER_DAY + r.hour * SECS_PER_HOUR + r.minute * SECS_PER_MIN
              + r.second;
      if (total > 64'hFFFF_FFFF) res.status = ST_TOO_LATE;
      else res.seconds = total[31:0];
    end
    return res;
  endfunction

  function automatic date_reading_t make_reading(bit ok, int year, int month, int day,
                                                 int hour, int minute, int second);
    date_reading_t r;
    r.read_ok = ok;
    r.year = 12'(year);
    r.month = 8'(month);
    r.day = 8'(day);
    r.hour = 8'(hour);
    r.minute = 8'(minute);
    r.second = 8'(second);
    return r;
  endfunction

  // Mostly well-formed readings around the 32-bit range, some raw noise
  function automatic date_reading_t random_reading();
    date_reading_t r;
    int            pick;
    pick = $urandom_range(99);
    if (pick < 75) begin
      r.read_ok = ($urandom_range(99) < 95);
      if (pick < 55) r.year = 12'($urandom_range(2106, 1970));
      else if (pick < 62) r.year = 12'($urandom_range(2106, 2096));
      else if (pick < 68) r.year = 12'($urandom_range(4095, 2107));
      else r.year = 12'($urandom_range(1969, 0));
      r.month = 8'($urandom_range(12, 1));
      r.day = 8'($urandom_range(31, 1));
      r.hour = 8'($urandom_range(23, 0));
      r.minute = 8'($urandom_range(59, 0));
      r.second = 8'($urandom_range(59, 0));
    end else begin
      r.read_ok = 1'($urandom_range(1));
      r.year = 12'($urandom);
      r.month = 8'($urandom);
      r.day = 8'($urandom);
      r.hour = 8'($urandom);
      r.minute = 8'($urandom);
      r.second = 8'($urandom);
    end
    return r;
  endfunction

  // Offer one reading and record its expected result once accepted
  task automatic send_reading(date_reading_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= r.read_ok;
    in_tdata <= {4'b0, r.second, r.minute, r.hour, r.day, r.month, r.year};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_epochs.push_back(predict_epoch(clock_present_model, r));
    readings_sent++;
  endtask

  // Hold the input idle until every expected result has come back
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_epochs.size() != 0) @(posedge clk);
  endtask

  task automatic set_clock_present(bit present);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_data <= present;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    clock_present_model = present;
    cfg_valid <= 1'b0;
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    epoch_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_epochs.size() == 0) begin
        $display("%0t: unexpected result status %0d epoch %0d", $time, out_tuser, out_tdata);
        failures++;
      end else begin
        exp_res = pending_epochs.pop_front();
        results_checked++;
        if (out_tuser <= ST_TOO_LATE) status_seen[out_tuser]++;
        if (out_tuser !== exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_res.status, out_tuser);
          failures++;
        end
        if (out_tdata !== exp_res.seconds) begin
          $display("%0t: epoch_seconds expected %0d actual %0d", $time, exp_res.seconds,
                   out_tdata);
          failures++;
        end
      end
    end
  end

  // Valid dates with no clock chip configured after reset
  task automatic test_absent_clock();
    send_reading(make_reading(1, 2024, 6, 15, 12, 30, 45));
    send_reading(make_reading(1, 1970, 1, 1, 0, 0, 0));
  endtask

  task automatic test_read_failure();
    send_reading(make_reading(0, 2024, 6, 15, 12, 30, 45));
    send_reading(make_reading(0, 1900, 255, 0, 255, 255, 255));
  endtask

  // Each field just out of its plausible range; implausible wins over early year
  task automatic test_field_limits();
    send_reading(make_reading(1, 2000, 0, 10, 1, 1, 1));
    send_reading(make_reading(1, 2000, 13, 10, 1, 1, 1));
    send_reading(make_reading(1, 2000, 255, 10, 1, 1, 1));
    send_reading(make_reading(1, 2000, 5, 0, 1, 1, 1));
    send_reading(make_reading(1, 2000, 5, 32, 1, 1, 1));
    send_reading(make_reading(1, 2000, 5, 10, 24, 1, 1));
    send_reading(make_reading(1, 2000, 5, 10, 1, 60, 1));
    send_reading(make_reading(1, 2000, 5, 10, 1, 1, 60));
    send_reading(make_reading(1, 1969, 255, 255, 255, 255, 255));
  endtask

  // Epoch start, last second before it, and both sides of the 32-bit limit
  task automatic test_epoch_bounds();
    send_reading(make_reading(1, 1970, 1, 1, 0, 0, 0));
    send_reading(make_reading(1, 1969, 12, 31, 23, 59, 59));
    send_reading(make_reading(1, 0, 1, 1, 0, 0, 0));
    send_reading(make_reading(1, 2106, 2, 7, 6, 28, 15));
    send_reading(make_reading(1, 2106, 2, 7, 6, 28, 16));
    send_reading(make_reading(1, 4095, 12, 31, 23, 59, 59));
  endtask

  // Leap days and days past the end of a month rolling into the next
  task automatic test_calendar_rollover();
    send_reading(make_reading(1, 2000, 2, 29, 8, 0, 0));
    send_reading(make_reading(1, 2100, 2, 29, 8, 0, 0));
    send_reading(make_reading(1, 2023, 2, 30, 23, 59, 59));
    send_reading(make_reading(1, 2024, 4, 31, 0, 0, 1));
  endtask

  // Random readings under one idling profile, drained once halfway
  task automatic run_random_readings(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_for_results();
      send_reading(random_reading());
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    clock_present_model = 1'b0;
    send_idle_pct = 15;
    recv_stall_pct = 45;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_absent_clock();
    set_clock_present(1'b1);
    test_read_failure();
    test_field_limits();
    test_epoch_bounds();
    test_calendar_rollover();

    run_random_readings(200, 15, 45);
    run_random_readings(200, 45, 15);
    set_clock_present(1'b0);
    run_random_readings(20, 0, 0);
    set_clock_present(1'b1);
    run_random_readings(200, 0, 0);

    // Let the pipeline empty, then watch for stray results
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d readings, checked %0d results with clock present toggled",
             readings_sent, results_checked);
    $display("Status mix: ok %0d, no clock %0d, implausible %0d, pre-1970 %0d, too late %0d",
             status_seen[ST_OK], status_seen[ST_NO_CLOCK], status_seen[ST_IMPLAUSIBLE],
             status_seen[ST_BEFORE_EPOCH], status_seen[ST_TOO_LATE]);
    if (failures == 0 && pending_epochs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### civil_date_to_epoch_seconds.f
+incdir+rtl
rtl/cdte_pkg.sv
rtl/cdte_front.sv
rtl/cdte_fifo.sv
rtl/cdte_back.sv
rtl/civil_date_to_epoch_seconds.sv
verif/tb_civil_date_to_epoch_seconds.sv
